// ===== rtl/ackc_pkg.sv =====
// ----------------------------------------------------------------------------
// ackc_pkg
// Shared types and constants for the keyed cache with use counts.
// ----------------------------------------------------------------------------
package ackc_pkg;

   // Table geometry
   localparam int CAPACITY = 8;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CFG_W    = 4;
   localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int KEY_W    = 32;
   localparam int HDL_W    = 32;
   localparam int ACT_W    = 32;

   // Reset value of the entry limit register
   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 4'd5;

   // Keys that are never evicted ('#USE' and '#AGE')
   localparam logic [KEY_W-1:0] KEY_USE = 32'h2355_5345;
   localparam logic [KEY_W-1:0] KEY_AGE = 32'h2341_4745;

   // Operation codes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_GET    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // Request beat
   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
      logic [HDL_W-1:0] handle;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [1:0]       status;
      logic [HDL_W-1:0] found_handle;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load;
      logic             scan;
      logic [IDX_W-1:0] idx;
      logic             exec;
   } cmd_type;

endpackage

// ===== rtl/activity_counted_keyed_cache_unit.sv =====
// ----------------------------------------------------------------------------
// activity_counted_keyed_cache_unit
// Keyed cache of up to eight key/handle entries with per-entry use counts.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. The unit then
// walks its eight slots one per cycle to find the key, the lowest free slot,
// the occupancy and the eviction candidate, and then updates the table in the
// exec state: busy stays high through the scan and the update, and the
// result beat appears on rsp_data with rsp_strobe high in the cycle after the
// update, for that one cycle only; the receiver must take it then, since it
// cannot stall the unit. A new operation may be started in the cycle the
// result is shown.
// The entry limit is written through csr_valid/csr_data (always ready) and
// should only be changed while the unit is not busy.
// ----------------------------------------------------------------------------
module activity_counted_keyed_cache_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ackc_pkg::req_type          req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ackc_pkg::CFG_W-1:0] csr_data,
   output logic                       rsp_strobe,
   output ackc_pkg::rsp_type          rsp_data
);

   ackc_pkg::cmd_type cmd;

   // Sequencer
   ackc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Table and response path
   ackc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/ackc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ackc_ctrl
// Sequencer: accepts a request, walks the table one slot per cycle, then
// issues the single update-and-respond step.
// ----------------------------------------------------------------------------
module ackc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output ackc_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [ackc_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       last_slot;

   assign last_slot = (idx_ff == ackc_pkg::IDX_W'(ackc_pkg::CAPACITY - 1));

   // Next state and slot counter
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               idx_in   = '0;
            end
         end
         S_SCAN: begin
            if (last_slot) begin
               state_in = S_EXEC;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Drive commands
   assign busy     = (state_ff != S_IDLE);
   assign cmd.load = (state_ff == S_IDLE) && start;
   assign cmd.scan = (state_ff == S_SCAN);
   assign cmd.idx  = idx_ff;
   assign cmd.exec = (state_ff == S_EXEC);

endmodule

// ===== rtl/ackc_dpath.sv =====
// ----------------------------------------------------------------------------
// ackc_dpath
// Entry storage, limit register, scan accumulators and the response register.
// ----------------------------------------------------------------------------
module ackc_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  ackc_pkg::cmd_type          cmd,
   input  ackc_pkg::req_type          req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ackc_pkg::CFG_W-1:0] csr_data,
   output logic                       rsp_strobe,
   output ackc_pkg::rsp_type          rsp_data
);

   localparam int IW = ackc_pkg::IDX_W;
   localparam int CW = ackc_pkg::CNT_W;
   localparam int LW = ackc_pkg::LIM_W;

   // Entry storage
   logic [ackc_pkg::CAPACITY-1:0] valid_ff, valid_in;
   logic [ackc_pkg::KEY_W-1:0]    key_ff [ackc_pkg::CAPACITY];
   logic [ackc_pkg::HDL_W-1:0]    hdl_ff [ackc_pkg::CAPACITY];
   logic [ackc_pkg::ACT_W-1:0]    act_ff [ackc_pkg::CAPACITY];

   // Limit register and latched request
   logic [ackc_pkg::CFG_W-1:0] max_ff;
   ackc_pkg::req_type          req_ff;

   // Scan accumulators
   logic                       hit_ff;
   logic [IW-1:0]              hit_slot_ff;
   logic [ackc_pkg::HDL_W-1:0] hit_hdl_ff;
   logic [ackc_pkg::ACT_W-1:0] hit_act_ff;
   logic                       free_ff;
   logic [IW-1:0]              free_slot_ff;
   logic [CW-1:0]              count_ff;
   logic                       vic_ff;
   logic [IW-1:0]              vic_slot_ff;
   logic [ackc_pkg::KEY_W-1:0] vic_key_ff;
   logic [ackc_pkg::ACT_W-1:0] vic_act_ff;

   // Response register
   logic              rsp_strobe_ff;
   ackc_pkg::rsp_type rsp_ff, rsp_in;

   // Entry write port
   logic                       wr_en;
   logic [IW-1:0]              wr_slot;
   logic [ackc_pkg::HDL_W-1:0] wr_hdl;
   logic [ackc_pkg::ACT_W-1:0] wr_act;
   logic                       clr_en, set_en;
   logic [IW-1:0]              clr_slot, set_slot;

   // Slot under scan
   logic                       rd_valid, rd_hit, rd_free, rd_vic;
   logic [ackc_pkg::KEY_W-1:0] rd_key;
   logic [ackc_pkg::ACT_W-1:0] rd_act;

   // Decision terms
   logic [LW-1:0] lim;
   logic          full;
   logic [IW-1:0] ins_slot;

   assign csr_ready = 1'b1;

   // Hold the entry limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= ackc_pkg::MAX_ENTRIES_RESET;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_data;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Classify the slot under scan
   assign rd_valid = valid_ff[cmd.idx];
   assign rd_key   = key_ff[cmd.idx];
   assign rd_act   = act_ff[cmd.idx];
   assign rd_hit   = rd_valid && (rd_key == req_ff.key) && !hit_ff;
   assign rd_free  = !rd_valid && !free_ff;
   assign rd_vic   = rd_valid && (rd_key != ackc_pkg::KEY_USE) &&
                     (rd_key != ackc_pkg::KEY_AGE) &&
                     (!vic_ff || (rd_act < vic_act_ff) ||
                      ((rd_act == vic_act_ff) && (rd_key < vic_key_ff)));

   // Accumulate hit, free slot, occupancy and eviction candidate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         vic_ff   <= 1'b0;
         count_ff <= '0;
      end else if (cmd.scan) begin
         count_ff <= count_ff + CW'(rd_valid);
         if (rd_hit) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= cmd.idx;
            hit_hdl_ff  <= hdl_ff[cmd.idx];
            hit_act_ff  <= rd_act;
         end
         if (rd_free) begin
            free_ff      <= 1'b1;
            free_slot_ff <= cmd.idx;
         end
         if (rd_vic) begin
            vic_ff      <= 1'b1;
            vic_slot_ff <= cmd.idx;
            vic_key_ff  <= rd_key;
            vic_act_ff  <= rd_act;
         end
      end
   end

   // Clamp the limit to 1..CAPACITY
   always_comb begin
      lim = LW'(max_ff);
      if (lim == '0) begin
         lim = LW'(1);
      end else if (lim > LW'(ackc_pkg::CAPACITY)) begin
         lim = LW'(ackc_pkg::CAPACITY);
      end
   end

   assign full     = (LW'(count_ff) >= lim);
   assign ins_slot = (full && !(free_ff && (free_slot_ff < vic_slot_ff))) ?
                     vic_slot_ff : free_slot_ff;

   // Decide the update and the response
   always_comb begin
      wr_en    = 1'b0;
      wr_slot  = hit_slot_ff;
      wr_hdl   = req_ff.handle;
      wr_act   = '0;
      clr_en   = 1'b0;
      clr_slot = hit_slot_ff;
      set_en   = 1'b0;
      set_slot = ins_slot;
      rsp_in   = '0;
      case (req_ff.mode)
         ackc_pkg::MODE_ADD: begin
            if (hit_ff) begin
               wr_en = (hit_hdl_ff != req_ff.handle);
            end else if (full && !vic_ff) begin
               rsp_in.status = ackc_pkg::STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               wr_slot = ins_slot;
               set_en  = 1'b1;
               if (full) begin
                  clr_en              = 1'b1;
                  clr_slot            = vic_slot_ff;
                  rsp_in.evicted      = 1'b1;
                  rsp_in.evicted_key  = vic_key_ff;
               end
            end
         end
         ackc_pkg::MODE_GET: begin
            if (hit_ff) begin
               wr_en               = 1'b1;
               wr_hdl              = hit_hdl_ff;
               wr_act              = (&hit_act_ff) ? hit_act_ff : hit_act_ff + 1'b1;
               rsp_in.found_handle = hit_hdl_ff;
            end else begin
               rsp_in.status = ackc_pkg::STAT_MISS;
            end
         end
         ackc_pkg::MODE_REMOVE: begin
            if (hit_ff) begin
               clr_en = 1'b1;
            end else begin
               rsp_in.status = ackc_pkg::STAT_MISS;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Update valid bits: drop the victim or removed entry first, then mark the new entry
   always_comb begin
      valid_in = valid_ff;
      if (cmd.exec && clr_en) begin
         valid_in[clr_slot] = 1'b0;
      end
      if (cmd.exec && set_en) begin
         valid_in[set_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write the entry fields
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         key_ff[wr_slot] <= req_ff.key;
         hdl_ff[wr_slot] <= wr_hdl;
         act_ff[wr_slot] <= wr_act;
      end
   end

   // Present the response beat for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
